@@ rtl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants for the modular inverse core.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

   localparam int unsigned STATUS_WIDTH = 1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK   = 1'b0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NONE = 1'b1;

endpackage

`default_nettype wire

@@ rtl/mie_req_if.sv @@
// ----------------------------------------------------------------------------
// mie_req_if
// Request channel: value and modulus with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mie_req_if #(
   parameter int unsigned DATA_WIDTH = 63
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] value;
   logic [DATA_WIDTH-1:0] modulus;

   modport source (output valid, output value, output modulus, input ready);
   modport sink   (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

@@ rtl/mie_rsp_if.sv @@
// ----------------------------------------------------------------------------
// mie_rsp_if
// Response channel: inverse and status with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mie_rsp_if #(
   parameter int unsigned DATA_WIDTH = 63
);
   logic                                valid;
   logic                                ready;
   logic [DATA_WIDTH-1:0]               inverse;
   logic [mie_pkg::STATUS_WIDTH-1:0]    status;

   modport source (output valid, output inverse, output status, input ready);
   modport sink   (input valid, input inverse, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/modular_inverse_euclid_core.sv @@
// Each Euclid step aligns the divisor, shift-subtracts and swaps; the first
// step reduces the value, then ST_FIX, ST_NEG and ST_DONE finish the item.
// Throughput: one item at a time; the shift-subtract divider yields one
// quotient bit per cycle and sets the pace.
// A finished item waits in the output register while the next is taken.
// Reset (synchronous, active high) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// modular_inverse_euclid_core
// Extended Euclid modular inverse with a bit-serial shift-subtract divider.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_euclid_core #(
   parameter int unsigned DATA_WIDTH = 63
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mie_req_if.sink    req_ch,
   mie_rsp_if.source  rsp_ch
);

   localparam int unsigned CW = $clog2(DATA_WIDTH);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_ALIGN = 7'b0000010,
      ST_SUB   = 7'b0000100,
      ST_SWAP  = 7'b0001000,
      ST_FIX   = 7'b0010000,
      ST_NEG   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [DATA_WIDTH-1:0] rp_ff, rp_in, rc_ff, rc_in;
   logic [DATA_WIDTH-1:0] cp_ff, cp_in, cc_ff, cc_in;
   logic [DATA_WIDTH-1:0] d_ff, d_in, e_ff, e_in;
   logic [DATA_WIDTH-1:0] m_ff, m_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  neg_ff, neg_in;
   logic                  fail_ff, fail_in;
   logic                  ov_ff, ov_in;
   logic [DATA_WIDTH-1:0] inv_ff, inv_in;
   logic [mie_pkg::STATUS_WIDTH-1:0] st_ff, st_in;

   logic [DATA_WIDTH-1:0] d_dbl;
   logic                  out_free;

   assign d_dbl    = {d_ff[DATA_WIDTH-2:0], 1'b0};
   assign out_free = !ov_ff || rsp_ch.ready;

   assign req_ch.ready   = (state_ff == ST_IDLE);
   assign rsp_ch.valid   = ov_ff;
   assign rsp_ch.inverse = inv_ff;
   assign rsp_ch.status  = st_ff;

   always_comb begin
      state_in = state_ff;
      rp_in = rp_ff; rc_in = rc_ff; cp_in = cp_ff; cc_in = cc_ff;
      d_in = d_ff; e_in = e_ff; m_in = m_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; fail_in = fail_ff;
      ov_in = ov_ff; inv_in = inv_ff; st_in = st_ff;
      if (ov_ff && rsp_ch.ready) begin
         ov_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               rp_in  = req_ch.value;
               rc_in  = req_ch.modulus;
               m_in   = req_ch.modulus;
               d_in   = req_ch.modulus;
               cp_in  = {{(DATA_WIDTH-1){1'b0}}, 1'b1};
               cc_in  = '0;
               e_in   = '0;
               cnt_in = '0;
               neg_in = 1'b0;
               state_in = (req_ch.modulus == '0) ? ST_FIX : ST_ALIGN;
            end
         end
         ST_ALIGN: begin
            if (!d_ff[DATA_WIDTH-1] && (d_dbl <= rp_ff)) begin
               d_in   = d_dbl;
               e_in   = {e_ff[DATA_WIDTH-2:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            if (d_ff <= rp_ff) begin
               rp_in = rp_ff - d_ff;
               cp_in = cp_ff + e_ff;
            end
            d_in = d_ff >> 1;
            e_in = e_ff >> 1;
            if (cnt_ff == '0) begin
               state_in = ST_SWAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SWAP: begin
            rp_in  = rc_ff;
            rc_in  = rp_ff;
            cp_in  = cc_ff;
            cc_in  = cp_ff;
            d_in   = rp_ff;
            e_in   = cp_ff;
            cnt_in = '0;
            neg_in = !neg_ff;
            state_in = (rp_ff == '0) ? ST_FIX : ST_ALIGN;
         end
         ST_FIX: begin
            fail_in = (m_ff == '0) || (rp_ff != {{(DATA_WIDTH-1){1'b0}}, 1'b1});
            if (cp_ff >= m_ff) begin
               cp_in = cp_ff - m_ff;
            end
            state_in = ST_NEG;
         end
         ST_NEG: begin
            if (neg_ff && (cp_ff != '0)) begin
               cp_in = m_ff - cp_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               ov_in    = 1'b1;
               inv_in   = fail_ff ? '0 : cp_ff;
               st_in    = fail_ff ? mie_pkg::STATUS_NONE : mie_pkg::STATUS_OK;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
      end
      rp_ff <= rp_in; rc_ff <= rc_in; cp_ff <= cp_in; cc_ff <= cc_in;
      d_ff <= d_in; e_ff <= e_in; m_ff <= m_in; cnt_ff <= cnt_in;
      neg_ff <= neg_in; fail_ff <= fail_in;
      inv_ff <= inv_in; st_ff <= st_in;
   end

`ifndef SYNTH
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && st_ff == mie_pkg::STATUS_NONE) |-> (inv_ff == '0))
      else $error("no-inverse item carries nonzero inverse");
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff == ST_ALIGN || state_ff == ST_FIX))
      else $error("accepted item did not start");
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (ov_ff && state_ff == ST_IDLE))
      else $error("finished item not loaded into output");
   a_sub_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SUB && d_ff <= rp_ff) |-> ({1'b0, cp_ff} + {1'b0, e_ff} <= {1'b0, m_ff}))
      else $error("coefficient exceeds modulus");
`endif

endmodule

`default_nettype wire

@@ verif/modular_inverse_euclid_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_euclid_checker
// Watches the request and response channels, computes the expected inverse
// and status for every accepted item and compares each response in order.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_euclid_checker #(
   parameter int unsigned DATA_WIDTH = 63
) (
   input  wire logic  clock,
   input  wire logic  reset,
   mie_req_if.sink    req_mon,
   mie_rsp_if.sink    rsp_mon,
   output int         fail_count,
   output int         pending_count,
   output int         ok_count,
   output int         none_count
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0]            inverse;
      logic [mie_pkg::STATUS_WIDTH-1:0] status;
   } inv_result_type;

   inv_result_type inverse_queue[$];

   function automatic inv_result_type compute_inverse(logic [DATA_WIDTH-1:0] v,
                                                      logic [DATA_WIDTH-1:0] m);
      logic [63:0]    r_prev, r_cur, c_prev, c_cur, q, r_next, c_next;
      bit             neg_prev, neg_cur;
      inv_result_type res;
      res.inverse = '0;
      res.status  = mie_pkg::STATUS_NONE;
      if (m == '0) return res;
      res.status = mie_pkg::STATUS_OK;
      if (m == DATA_WIDTH'(1)) return res;
      r_prev = 64'(m);
      r_cur = 64'(v) % 64'(m);
      c_prev = 64'd0;
      c_cur = 64'd1;
      neg_prev = 1'b1;
      neg_cur = 1'b0;
      while (r_cur != 64'd0) begin
         q = r_prev / r_cur;
         r_next = r_prev - q * r_cur;
         c_next = c_prev + q * c_cur;
         r_prev = r_cur;
         r_cur = r_next;
         c_prev = c_cur;
         c_cur = c_next;
         neg_prev = neg_cur;
         neg_cur = !neg_cur;
      end
      if (r_prev != 64'd1) begin
         res.status = mie_pkg::STATUS_NONE;
         return res;
      end
      c_prev = c_prev % 64'(m);
      if (neg_prev && c_prev != 64'd0) c_prev = 64'(m) - c_prev;
      res.inverse = c_prev[DATA_WIDTH-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      inv_result_type exp_res;
      if (reset) begin
         fail_count    <= 0;
         ok_count      <= 0;
         none_count    <= 0;
         pending_count <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            inverse_queue.push_back(compute_inverse(req_mon.value, req_mon.modulus));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (inverse_queue.size() == 0) begin
               if (fail_count < 10)
                  $display("tb: unexpected response inverse=%0d status=%0d",
                           rsp_mon.inverse, rsp_mon.status);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = inverse_queue.pop_front();
               if (exp_res.status == mie_pkg::STATUS_OK) ok_count <= ok_count + 1;
               else none_count <= none_count + 1;
               if (rsp_mon.inverse !== exp_res.inverse ||
                   rsp_mon.status !== exp_res.status) begin
                  if (fail_count < 10)
                     $display("tb: mismatch exp inverse=%0d status=%0d got inverse=%0d status=%0d",
                              exp_res.inverse, exp_res.status,
                              rsp_mon.inverse, rsp_mon.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= inverse_queue.size();
      end
   end
endmodule

`default_nettype wire

@@ verif/modular_inverse_euclid_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_euclid_core_tb
// Drives directed and random value/modulus items with random gaps and
// response stalls, including one long stall; the checker scores results.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_euclid_core_tb;

   localparam int unsigned DW = 63;
   localparam int RANDOM_ITEMS = 500;
   localparam longint CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count, ok_count, none_count;
   longint cycle_count = 0;
   bit   long_hold = 1'b0;
   int   sent_count = 0;

   mie_req_if #(.DATA_WIDTH(DW)) req_ch ();
   mie_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

   modular_inverse_euclid_core #(.DATA_WIDTH(DW)) dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch)
   );

   modular_inverse_euclid_checker #(.DATA_WIDTH(DW)) checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count),
      .ok_count(ok_count), .none_count(none_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      req_ch.modulus = '1;
   end

   function automatic int gap_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 600);
      return $urandom_range(0, 3);
   endfunction

   function automatic logic [DW-1:0] rand_word();
      logic [DW-1:0] w;
      w = DW'({$urandom, $urandom});
      case ($urandom_range(0, 3))
         0: w = w >> $urandom_range(0, DW - 1);
         1: w = w >> $urandom_range(DW - 16, DW - 1);
         default: ;
      endcase
      return w;
   endfunction

   task automatic send_item(logic [DW-1:0] v, logic [DW-1:0] m);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.value   <= v;
      req_ch.modulus <= m;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   always @(posedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else if (long_hold) rsp_ch.ready <= 1'b0;
      else rsp_ch.ready <= ($urandom_range(0, 9) < 7);
   end

   initial begin
      logic [DW-1:0] v, m, k;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_item(63'd3, 63'd1);
      send_item('1, 63'd1);
      send_item(63'd0, 63'd7);
      send_item(63'd0, '1);
      send_item(63'd6, 63'd9);
      send_item(63'd3, 63'd7);
      send_item(63'd10, 63'd7);
      send_item('1, '1);
      send_item('1 - 63'd1, '1);
      send_item(63'd1, '1);
      send_item('1, 63'd2);
      send_item(63'd2, '1 - 63'd24);
      send_item(63'd1, 63'd2);
      send_item(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAB);
      send_item(63'h2AAA_AAAA_AAAA_AAAA, 63'h5555_5555_5555_5555);
      send_item(63'd7540113804746346429, 63'd4660046610375530309);
      send_item(63'd1, 63'd1 << 62);
      send_item(63'd12, 63'd18);
      // long response stall while requests keep coming
      fork
         begin
            long_hold = 1'b1;
            repeat (3000) @(posedge clock);
            long_hold = 1'b0;
         end
         begin
            repeat (6) send_item(rand_word(), rand_word() | 1);
         end
      join
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         v = rand_word();
         m = rand_word();
         case ($urandom_range(0, 7))
            0: m = 63'd1;
            1: begin
               k = DW'(($urandom & 32'hFF) + 2);
               m = (m >> 8) * k;
               v = (v >> 8) * k;
            end
            2: v = '0;
            default: ;
         endcase
         if (m == 0) m = 63'd1;
         send_item(v, m);
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (500) @(posedge clock);
      $display("tb: %0d items sent, %0d with an inverse, %0d without",
               sent_count, ok_count, none_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

`default_nettype wire

@@ filelist.f @@
rtl/mie_pkg.sv
rtl/mie_req_if.sv
rtl/mie_rsp_if.sv
rtl/modular_inverse_euclid_core.sv
verif/modular_inverse_euclid_checker.sv
verif/modular_inverse_euclid_core_tb.sv
